### rtl/core/stp_pkg.sv
// Shared types, constants and the entry update function of the twister generator.
package stp_pkg;

  localparam int STATE_ENTRIES = 156;
  localparam int TOTAL_WORDS   = 4 * STATE_ENTRIES;
  localparam int POS_W         = $clog2(TOTAL_WORDS + 1);
  localparam int ADDR_W        = $clog2(STATE_ENTRIES);
  localparam int FAR_OFFSET    = 71;
  localparam int SHIFT_A       = 11;
  localparam int SHIFT_B       = 7;
  localparam int SHIFT_C       = 17;
  localparam int SEED_SHIFT    = 30;

  localparam logic [31:0] SEED_MULT = 32'd1812433253;

  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef logic [31:0]       word_t;
  typedef logic [127:0]      entry_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SEED_MUL = 6'b000010,
    ST_SEED_ADD = 6'b000100,
    ST_REGEN    = 6'b001000,
    ST_DRAW_RD  = 6'b010000,
    ST_DRAW_OUT = 6'b100000
  } state_t;

  // One in-place entry update; later lanes see the lanes already updated.
  function automatic entry_t regen_entry(entry_t a, entry_t b, entry_t c);
    word_t a0, a1, a2, a3;
    word_t b0, b1, b2, b3;
    word_t c0, c1, c2, c3;
    begin
      a0 = a[31:0];   a1 = a[63:32];  a2 = a[95:64];  a3 = a[127:96];
      b0 = b[31:0];   b1 = b[63:32];  b2 = b[95:64];  b3 = b[127:96];
      c0 = c[31:0];   c1 = c[63:32];  c2 = c[95:64];  c3 = c[127:96];
      a0 = a0 ^ (a1 << SHIFT_A) ^ b0 ^ (b1 >> SHIFT_C) ^ c0 ^ (c3 << SHIFT_B);
      a1 = a1 ^ (a0 << SHIFT_A) ^ b1 ^ (b2 >> SHIFT_C) ^ c1 ^ (c0 << SHIFT_B);
      a2 = a2 ^ (a3 << SHIFT_A) ^ b3 ^ (b3 >> SHIFT_C) ^ c2 ^ (c1 << SHIFT_B);
      a3 = a3 ^ (a2 << SHIFT_A) ^ b3 ^ (b0 >> SHIFT_C) ^ c3 ^ (c2 << SHIFT_B);
      regen_entry = {a3, a2, a1, a0};
    end
  endfunction

endpackage

### rtl/core/simd_twister_prng_core.sv
// Twister pseudo-random generator: state memory, seeding, regeneration and draw logic.
//
// Usage: one input channel (in_valid / in_stall) carries an item with in_command and
// in_seed_value. A seed item (command 0) fills the 156 x 128-bit state memory with
// the 1812433253 recurrence and gives no result. A draw item (command 1) gives one
// 32-bit word on the result channel (out_valid / out_stall).
// Draw sequence: a draw reads the memory, then loads the output register, and no
// new item is accepted until it is done. Every 624 words the store is
// regenerated in place first: each entry takes three reads on the single read
// port, then one write, before that draw reads its word.
// A seed handles each word as a multiply, then an add.
// in_stall is high whenever the sequencer is busy; a finished word sits in the
// output register, so a seed may be taken while that word still waits.
// If the receiver stalls, the word holds in the output register, and a following
// draw waits in its last cycle until the register frees.
// Reset clears the control state only. The memory is left unwritten: until the first
// seed, draws return zero, which is what an all-zero store yields forever.
module simd_twister_prng_core
  import stp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  in_command,
  input  word_t in_seed_value,
  output logic  out_valid,
  input  logic  out_stall,
  output word_t out_random_word
);

  // state memory, one read and one write port, registered read data
  entry_t mem [STATE_ENTRIES];
  entry_t rdata_r;
  logic   rd_en, wr_en;
  addr_t  rd_addr, wr_addr;
  entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // control
  state_t state_r, state_nxt;
  pos_t   pos_r, pos_nxt;
  logic   seeded_r, seeded_nxt;
  logic   out_valid_r, out_valid_nxt;

  // payload
  word_t  out_word_r, out_word_nxt;
  pos_t   k_r, k_nxt;            // word index during seeding
  word_t  prev_r, prev_nxt;
  word_t  prod_r, prod_nxt;
  addr_t  ent_r, ent_nxt;        // entry index during regeneration
  logic [1:0] rs_r, rs_nxt;      // regeneration sub-step
  entry_t a_r, a_nxt, b_r, b_nxt;
  logic [1:0] lane_r, lane_nxt;
  logic   zero_r, zero_nxt;

  // lanes 0..2 of the entry being seeded
  word_t      lane_buf_r [3];
  logic       buf_we;
  logic [1:0] buf_idx;
  word_t      buf_data;

  word_t           seed_v;
  logic [ADDR_W:0] far_sum;
  addr_t           far_idx, near_idx;

  assign seed_v  = prod_r + word_t'(k_r);
  assign far_sum = {1'b0, ent_r} + (ADDR_W+1)'(FAR_OFFSET);
  assign far_idx = (far_sum >= (ADDR_W+1)'(STATE_ENTRIES))
                   ? addr_t'(far_sum - (ADDR_W+1)'(STATE_ENTRIES)) : addr_t'(far_sum);
  assign near_idx = (ent_r >= addr_t'(2)) ? addr_t'(ent_r - addr_t'(2))
                                          : addr_t'(ent_r + addr_t'(STATE_ENTRIES - 2));

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    seeded_nxt    = seeded_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    k_nxt         = k_r;
    prev_nxt      = prev_r;
    prod_nxt      = prod_r;
    ent_nxt       = ent_r;
    rs_nxt        = rs_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    lane_nxt      = lane_r;
    zero_nxt      = zero_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    buf_we        = 1'b0;
    buf_idx       = '0;
    buf_data      = '0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_SEED) begin
            prev_nxt  = in_seed_value;
            buf_we    = 1'b1;
            buf_data  = in_seed_value;
            k_nxt     = pos_t'(1);
            state_nxt = ST_SEED_MUL;
          end else if (!seeded_r) begin
            zero_nxt  = 1'b1;
            state_nxt = ST_DRAW_OUT;
          end else if (pos_r == pos_t'(TOTAL_WORDS)) begin
            ent_nxt   = '0;
            rs_nxt    = '0;
            state_nxt = ST_REGEN;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = pos_r[ADDR_W+1:2];
            lane_nxt  = pos_r[1:0];
            zero_nxt  = 1'b0;
            pos_nxt   = pos_r + pos_t'(1);
            state_nxt = ST_DRAW_OUT;
          end
        end
      end
      ST_SEED_MUL: begin
        prod_nxt  = SEED_MULT * (prev_r ^ (prev_r >> SEED_SHIFT));
        state_nxt = ST_SEED_ADD;
      end
      ST_SEED_ADD: begin
        prev_nxt = seed_v;
        if (k_r[1:0] == 2'd3) begin
          wr_en   = 1'b1;
          wr_addr = k_r[ADDR_W+1:2];
          wr_data = {seed_v, lane_buf_r[2], lane_buf_r[1], lane_buf_r[0]};
        end else begin
          buf_we   = 1'b1;
          buf_idx  = k_r[1:0];
          buf_data = seed_v;
        end
        if (k_r == pos_t'(TOTAL_WORDS - 1)) begin
          pos_nxt    = pos_t'(TOTAL_WORDS);
          seeded_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          k_nxt     = k_r + pos_t'(1);
          state_nxt = ST_SEED_MUL;
        end
      end
      ST_REGEN: begin
        rs_nxt = rs_r + 2'd1;
        case (rs_r)
          2'd0: begin
            rd_en   = 1'b1;
            rd_addr = ent_r;
          end
          2'd1: begin
            a_nxt   = rdata_r;
            rd_en   = 1'b1;
            rd_addr = far_idx;
          end
          2'd2: begin
            b_nxt   = rdata_r;
            rd_en   = 1'b1;
            rd_addr = near_idx;
          end
          default: begin
            // earlier entries are already written back, so wrapped reads see new values
            wr_en   = 1'b1;
            wr_addr = ent_r;
            wr_data = regen_entry(a_r, b_r, rdata_r);
            if (ent_r == addr_t'(STATE_ENTRIES - 1)) begin
              state_nxt = ST_DRAW_RD;
            end else begin
              ent_nxt = ent_r + addr_t'(1);
            end
          end
        endcase
      end
      ST_DRAW_RD: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        lane_nxt  = 2'd0;
        zero_nxt  = 1'b0;
        pos_nxt   = pos_t'(1);
        state_nxt = ST_DRAW_OUT;
      end
      ST_DRAW_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = zero_r ? '0 : rdata_r[{lane_r, 5'b0} +: 32];
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    k_r        <= k_nxt;
    prev_r     <= prev_nxt;
    prod_r     <= prod_nxt;
    ent_r      <= ent_nxt;
    rs_r       <= rs_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    lane_r     <= lane_nxt;
    zero_r     <= zero_nxt;
    if (buf_we) lane_buf_r[buf_idx] <= buf_data;
  end

endmodule

### rtl/core/stp_port_checker.sv
// Port-level checks for the twister generator, bound to its top level.
module stp_port_checker
  import stp_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_stall,
  input logic  in_command,
  input logic  out_valid,
  input logic  out_stall,
  input word_t out_random_word
);

  // a waiting item is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_random_word))
    else $error("stalled result item changed");

  // a seed keeps the block busy for its fill
  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == CMD_SEED) |=> in_stall)
    else $error("input taken right after a seed item");

  // a new result only appears at the end of busy draw work
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result item without draw work");

  // nothing leaves the block right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind simd_twister_prng_core stp_port_checker u_stp_port_checker (.*);

### tb/simd_twister_prng_core_test.sv
// Self-checking testbench for the twister generator core: seeds, draws and regeneration.
module simd_twister_prng_core_test;
  import stp_pkg::*;

  // Run limits. The slowest legal run is roughly 1300 items, each of them
  // facing the longest input gap and the longest result stall, plus the
  // seed fills and the regeneration passes. The limit is that figure
  // several times over.
  localparam int CYCLE_LIMIT   = 1000000;
  // Idle time after the last result. It outlasts the busy time of a trailing
  // seed, so any stray result would show up in this window.
  localparam int SETTLE_CYCLES = 1400;
  localparam int REPORT_MAX    = 10;

  // One pending request for the input channel.
  typedef struct {
    logic  cmd;
    word_t seed;
    int    gap;    // idle cycles before the item is offered
    bit    drain;  // hold the item until every expected word has arrived
  } prng_op_t;

  logic  clk;
  logic  rst_n         = 1'b0;
  logic  in_valid      = 1'b0;
  logic  in_command    = CMD_SEED;
  word_t in_seed_value = '0;
  logic  out_stall     = 1'b0;
  logic  in_stall;
  logic  out_valid;
  word_t out_random_word;

  prng_op_t op_q[$];
  word_t    pending_words[$];
  prng_op_t cur_op;
  bit       op_loaded  = 1'b0;
  bit       in_taken   = 1'b0;
  int       gap_left   = 0;
  int       stall_left = 0;
  bit       stall_calm = 1'b0;
  int       errors     = 0;
  int       ops_built  = 0;

  // Predictor copy of the generator state: entries as four 32-bit lanes.
  word_t       twist_mem [STATE_ENTRIES][4];
  int unsigned word_idx;

  simd_twister_prng_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_random_word (out_random_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hang guard.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Seed fill: lane k = MULT * (prev ^ (prev >> 30)) + k, all mod 2^32,
  // counted across the whole store. The read index lands on "exhausted".
  function automatic void seed_fill(word_t s);
    word_t prev;
    word_t v;
    prev = s;
    twist_mem[0][0] = s;
    for (int k = 1; k < TOTAL_WORDS; k++) begin
      v = SEED_MULT * (prev ^ (prev >> SEED_SHIFT)) + word_t'(k);
      twist_mem[k >> 2][k & 3] = v;
      prev = v;
    end
    word_idx = TOTAL_WORDS;
  endfunction

  // In-place regeneration, entries in ascending order. Far neighbor at +71
  // and near neighbor at -2 both wrap; lanes updated earlier in the same
  // entry feed the later lanes. The odd lane picks are intentional.
  function automatic void regen_pass();
    word_t a [4];
    word_t b [4];
    word_t c [4];
    int    bi;
    int    ci;
    for (int i = 0; i < STATE_ENTRIES; i++) begin
      bi = (i + FAR_OFFSET) % STATE_ENTRIES;
      ci = (i + STATE_ENTRIES - 2) % STATE_ENTRIES;
      for (int l = 0; l < 4; l++) begin
        a[l] = twist_mem[i][l];
        b[l] = twist_mem[bi][l];
        c[l] = twist_mem[ci][l];
      end
      a[0] = a[0] ^ (a[1] << SHIFT_A) ^ b[0] ^ (b[1] >> SHIFT_C) ^ c[0] ^ (c[3] << SHIFT_B);
      a[1] = a[1] ^ (a[0] << SHIFT_A) ^ b[1] ^ (b[2] >> SHIFT_C) ^ c[1] ^ (c[0] << SHIFT_B);
      a[2] = a[2] ^ (a[3] << SHIFT_A) ^ b[3] ^ (b[3] >> SHIFT_C) ^ c[2] ^ (c[1] << SHIFT_B);
      a[3] = a[3] ^ (a[2] << SHIFT_A) ^ b[3] ^ (b[0] >> SHIFT_C) ^ c[3] ^ (c[2] << SHIFT_B);
      for (int l = 0; l < 4; l++) twist_mem[i][l] = a[l];
    end
  endfunction

  // Next word: regenerate first once all 624 words have been handed out.
  function automatic word_t draw_word();
    word_t w;
    if (word_idx >= TOTAL_WORDS) begin
      regen_pass();
      word_idx = 0;
    end
    w = twist_mem[word_idx >> 2][word_idx & 3];
    word_idx++;
    return w;
  endfunction

  // Queue one request. Every fourth block of 64 items runs with no gaps.
  task automatic push_op(logic cmd, word_t sv, bit drain);
    prng_op_t op;
    op.cmd   = cmd;
    op.seed  = sv;
    op.drain = drain;
    op.gap   = (((ops_built / 64) % 4) == 3) ? 0 : rand_gap();
    op_q.push_back(op);
    ops_built++;
  endtask

  task automatic flag_error(string msg);
    if (errors < REPORT_MAX) $display("%s", msg);
    errors++;
  endtask

  // Sender. Items are offered at the falling edge; a new one goes out only
  // once the previous one was taken. valid gets one assignment per edge, so
  // back-to-back items keep it high without a glitch.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (!op_loaded && op_q.size() != 0) begin
        cur_op    = op_q.pop_front();
        op_loaded = 1'b1;
        gap_left  = cur_op.gap;
      end
      if (op_loaded && gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (op_loaded && !(cur_op.drain && pending_words.size() != 0)) begin
        in_valid      <= 1'b1;
        in_command    <= cur_op.cmd;
        in_seed_value <= cur_op.seed;
        op_loaded     = 1'b0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: random stalls, with calm stretches that toggle
  // on a slow random schedule.
  always @(negedge clk) begin
    logic st;
    st = 1'b0;
    if (rst_n) begin
      if ($urandom_range(0, 499) == 0) stall_calm = !stall_calm;
      if (stall_left > 0) begin
        stall_left--;
        st = 1'b1;
      end else if (!stall_calm && $urandom_range(0, 3) == 0) begin
        stall_left = rand_gap();
        st = 1'b1;
      end
    end
    out_stall <= st;
  end

  // Rising edge: check the outgoing word first, then fold the accepted item
  // into the predictor. A draw cannot come out on the edge it goes in.
  always @(posedge clk) begin
    word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          flag_error($sformatf("unexpected word %h with nothing pending", out_random_word));
        end else begin
          want = pending_words.pop_front();
          if (out_random_word !== want)
            flag_error($sformatf("random_word mismatch: expected %h, got %h",
                                 want, out_random_word));
        end
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        if (in_command == CMD_SEED) seed_fill(in_seed_value);
        else pending_words.push_back(draw_word());
      end
    end
  end

  initial begin
    // Predictor starts from the reset state: all-zero store, index zero.
    for (int i = 0; i < STATE_ENTRIES; i++)
      for (int l = 0; l < 4; l++) twist_mem[i][l] = '0;
    word_idx = 0;

    // Directed part.
    // Draws before any seed read the all-zero store.
    push_op(CMD_DRAW, '0, 1'b0);
    push_op(CMD_DRAW, 32'hFFFF_FFFF, 1'b0);
    push_op(CMD_DRAW, $urandom, 1'b0);
    // Seed extremes; the first draw after a seed forces a regeneration pass.
    push_op(CMD_SEED, 32'h0000_0000, 1'b0);
    push_op(CMD_DRAW, $urandom, 1'b0);
    push_op(CMD_DRAW, $urandom, 1'b0);
    push_op(CMD_DRAW, $urandom, 1'b0);
    push_op(CMD_SEED, 32'hFFFF_FFFF, 1'b0);
    push_op(CMD_DRAW, '0, 1'b0);
    push_op(CMD_DRAW, 32'hFFFF_FFFF, 1'b0);
    // Back-to-back seeds: the second one wins.
    push_op(CMD_SEED, $urandom, 1'b0);
    push_op(CMD_SEED, 32'h8000_0000, 1'b0);
    push_op(CMD_DRAW, $urandom, 1'b0);
    push_op(CMD_DRAW, $urandom, 1'b0);
    // Sender holds off until the pipe is empty, then reseeds mid-stream.
    push_op(CMD_SEED, 32'h0000_0001, 1'b1);
    push_op(CMD_DRAW, $urandom, 1'b0);
    push_op(CMD_DRAW, $urandom, 1'b1);

    // Long stream from one seed: crosses three regeneration passes, the later
    // ones working on an already regenerated store.
    push_op(CMD_SEED, $urandom, 1'b0);
    for (int n = 0; n < 1260; n++)
      push_op(CMD_DRAW, $urandom, ($urandom_range(0, 99) < 3));

    // Short mixed tail: frequent reseeds cut streams at odd points.
    for (int n = 0; n < 60; n++)
      push_op(($urandom_range(0, 3) == 0) ? CMD_SEED : CMD_DRAW, $urandom,
              ($urandom_range(0, 99) < 5));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Everything sent, then everything received, then a quiet window.
    while (op_q.size() != 0 || op_loaded || in_valid) @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
